// File: rtl/aff_pkg.sv
`timescale 1ns / 1ps
package aff_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WORD_WIDTH  = 32;
    localparam int ARG_WIDTH   = 32;
    localparam int PROD_WIDTH  = 2 * WORD_WIDTH - FRAC_BITS;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int EXT_WIDTH   = (SUM_WIDTH > ARG_WIDTH + 1) ? SUM_WIDTH : ARG_WIDTH + 1;
    localparam int MAT_ROWS    = 3;
    localparam int MAT_COLS    = 2;
    localparam int MAT_ENTRIES = MAT_ROWS * MAT_COLS;
    localparam int IDX_WIDTH   = $clog2(MAT_ENTRIES);
    localparam int ROW_WIDTH   = 2;
    localparam int COL_WIDTH   = 2;
    localparam int OP_WIDTH    = 3;
    localparam int S_DATA_WIDTH = 72;
    localparam int M_DATA_WIDTH = 64;

    typedef logic signed [WORD_WIDTH-1:0] t_word;
    typedef logic signed [PROD_WIDTH-1:0] t_prod;
    typedef logic signed [EXT_WIDTH-1:0]  t_ext;
    typedef logic signed [ARG_WIDTH-1:0]  t_arg;
    typedef t_word [MAT_ENTRIES-1:0]      t_mat;
    typedef t_prod [MAT_ROWS-1:0]         t_prod_row;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_IDENTITY  = 3'd0,
        OP_SET       = 3'd1,
        OP_TRANSLATE = 3'd2,
        OP_SCALE     = 3'd3,
        OP_ROTATE    = 3'd4,
        OP_POINT     = 3'd5
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [ROW_WIDTH-1:0] row;
        logic [COL_WIDTH-1:0] col;
        t_word                arg_a;
        t_word                arg_b;
    } t_cmd;

    // per matrix row: m0*a, m1*b, m0*b, m1*a (all truncated)
    typedef struct packed {
        t_prod_row m0a;
        t_prod_row m1b;
        t_prod_row m0b;
        t_prod_row m1a;
    } t_prods;

    localparam t_word WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam t_word WORD_ONE = (FRAC_BITS < WORD_WIDTH - 1) ?
                                 (t_word'(1) << FRAC_BITS) : WORD_MAX;

    function automatic t_word sat_word(input t_ext v);
        logic in_range;
        in_range = (v[EXT_WIDTH-1:WORD_WIDTH-1] ==
                    {(EXT_WIDTH-WORD_WIDTH+1){v[EXT_WIDTH-1]}});
        if (in_range) begin
            return v[WORD_WIDTH-1:0];
        end else if (v[EXT_WIDTH-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    // full product, then arithmetic shift (rounds toward minus infinity)
    function automatic t_prod mul_trunc(input t_word a, input t_word b);
        logic signed [2*WORD_WIDTH-1:0] p;
        p = a * b;
        return t_prod'(p >>> FRAC_BITS);
    endfunction

    function automatic t_mat mat_identity();
        t_mat m;
        for (int k = 0; k < MAT_ENTRIES; k++) begin
            m[k] = '0;
        end
        m[0] = WORD_ONE;
        m[3] = WORD_ONE;
        return m;
    endfunction

endpackage

// File: rtl/aff_mul_array.sv
`timescale 1ns / 1ps
module aff_mul_array import aff_pkg::*; (
    input  t_mat   i_mat,
    input  t_word  i_a,
    input  t_word  i_b,
    output t_prods o_prods
);

    // one bank of four multipliers per row, shared by scale, rotate and point
    for (genvar r = 0; r < MAT_ROWS; r++) begin : g_row
        assign o_prods.m0a[r] = mul_trunc(i_mat[2*r],   i_a);
        assign o_prods.m1b[r] = mul_trunc(i_mat[2*r+1], i_b);
        assign o_prods.m0b[r] = mul_trunc(i_mat[2*r],   i_b);
        assign o_prods.m1a[r] = mul_trunc(i_mat[2*r+1], i_a);
    end

endmodule

// File: rtl/aff_exec.sv
`timescale 1ns / 1ps
module aff_exec import aff_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_cmd i_cmd,
    output t_arg o_x,
    output t_arg o_y
);

    t_mat                 r_mat;
    t_mat                 n_mat;
    t_prods               w_prods;
    logic [IDX_WIDTH-1:0] w_idx;
    t_ext                 w_xs;
    t_ext                 w_ys;
    t_ext                 w_x_ext;
    t_ext                 w_y_ext;

    aff_mul_array u_mul (
        .i_mat   (r_mat),
        .i_a     (i_cmd.arg_a),
        .i_b     (i_cmd.arg_b),
        .o_prods (w_prods)
    );

    // row*2 + col, valid only when col < 2
    assign w_idx = IDX_WIDTH'({i_cmd.row, i_cmd.col[0]});

    always_comb begin
        n_mat = r_mat;
        case (i_cmd.op)
            OP_IDENTITY: begin
                n_mat = mat_identity();
            end
            OP_SET: begin
                if (i_cmd.row < ROW_WIDTH'(MAT_ROWS) && i_cmd.col < COL_WIDTH'(MAT_COLS)) begin
                    n_mat[w_idx] = i_cmd.arg_a;
                end
            end
            OP_TRANSLATE: begin
                n_mat[4] = sat_word(t_ext'($signed(r_mat[4])) + t_ext'(i_cmd.arg_a));
                n_mat[5] = sat_word(t_ext'($signed(r_mat[5])) + t_ext'(i_cmd.arg_b));
            end
            OP_SCALE: begin
                for (int r = 0; r < MAT_ROWS; r++) begin
                    n_mat[2*r]   = sat_word(t_ext'($signed(w_prods.m0a[r])));
                    n_mat[2*r+1] = sat_word(t_ext'($signed(w_prods.m1b[r])));
                end
            end
            OP_ROTATE: begin
                for (int r = 0; r < MAT_ROWS; r++) begin
                    n_mat[2*r]   = sat_word(t_ext'($signed(w_prods.m0a[r]))
                                          - t_ext'($signed(w_prods.m1b[r])));
                    n_mat[2*r+1] = sat_word(t_ext'($signed(w_prods.m0b[r]))
                                          + t_ext'($signed(w_prods.m1a[r])));
                end
            end
            default: begin
            end
        endcase
    end

    // x' = x*m00 + y*m10 + m20, y' = x*m01 + y*m11 + m21
    assign w_xs = t_ext'($signed(w_prods.m0a[0])) + t_ext'($signed(w_prods.m0b[1]))
                + t_ext'($signed(r_mat[4]));
    assign w_ys = t_ext'($signed(w_prods.m1a[0])) + t_ext'($signed(w_prods.m1b[1]))
                + t_ext'($signed(r_mat[5]));

    assign w_x_ext = t_ext'(sat_word(w_xs));
    assign w_y_ext = t_ext'(sat_word(w_ys));
    assign o_x     = w_x_ext[ARG_WIDTH-1:0];
    assign o_y     = w_y_ext[ARG_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= mat_identity();
        end else if (i_fire) begin
            r_mat <= n_mat;
        end
    end

endmodule

// File: rtl/affine_transform_2d_unit.sv
`timescale 1ns / 1ps
// A transform-point word is held in the command register, then written to the result queue that drives m_axis.
// Throughput: one command word per cycle; each command sees the matrix left by
// the one before it. The output is a two-word queue, so input stalls only when
// two results are waiting unread.
// Reset (synchronous, active low): matrix set to identity, no word held.
module affine_transform_2d_unit import aff_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // row[1:0], col[3:2], arg_a[35:4], arg_b[67:36], zero fill
    input  logic [S_DATA_WIDTH-1:0] s_axis_tdata,
    // op[2:0]
    input  logic [OP_WIDTH-1:0]     s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // x_out[31:0], y_out[63:32]
    output logic [M_DATA_WIDTH-1:0] m_axis_tdata
);

    logic                    r_in_valid;
    t_cmd                    r_cmd;
    logic                    w_in_acc;
    logic                    w_needs_out;
    logic                    w_full;
    logic                    w_fire;
    logic                    w_push;
    logic                    w_pop;
    t_arg                    w_x;
    t_arg                    w_y;
    logic [M_DATA_WIDTH-1:0] r_buf [2];
    logic                    r_wptr;
    logic                    r_rptr;
    logic [1:0]              r_count;

    assign w_needs_out   = (r_cmd.op == OP_POINT);
    assign w_full        = (r_count == 2'd2);
    assign w_fire        = r_in_valid && (!w_needs_out || !w_full);
    assign w_push        = w_fire && w_needs_out;
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // args are clamped to the matrix word width on the way in
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd.op    <= t_op'(s_axis_tuser);
            r_cmd.row   <= s_axis_tdata[1:0];
            r_cmd.col   <= s_axis_tdata[3:2];
            r_cmd.arg_a <= sat_word(t_ext'($signed(s_axis_tdata[35:4])));
            r_cmd.arg_b <= sat_word(t_ext'($signed(s_axis_tdata[67:36])));
        end
    end

    aff_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_cmd   (r_cmd),
        .o_x     (w_x),
        .o_y     (w_y)
    );

    // two-word result queue
    assign m_axis_tvalid = (r_count != 2'd0);
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wptr] <= {w_y, w_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: dv/affine_transform_2d_unit_tb.sv
`timescale 1ns / 1ps
module affine_transform_2d_unit_tb;
    import aff_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEMS_PER_MODE = 250;

    // op codes the block does not decode; they must leave the matrix alone
    localparam logic [OP_WIDTH-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_7 = 3'd7;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_word x;
        t_word y;
    } t_point;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // row[1:0], col[3:2], arg_a[35:4], arg_b[67:36], zero fill
    logic [S_DATA_WIDTH-1:0] s_axis_tdata  = '0;
    // op[2:0]
    logic [OP_WIDTH-1:0]     s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // x_out[31:0], y_out[63:32]
    logic [M_DATA_WIDTH-1:0] m_axis_tdata;

    t_word  mat_model [MAT_ENTRIES];
    t_point pending_points [$];
    int     error_count        = 0;
    int     sender_idle_pct    = 0;
    int     receiver_stall_pct = 0;

    affine_transform_2d_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- matrix predictor ----------------

    function automatic t_wide qmul(input t_word a, input t_word b);
        t_wide wa;
        t_wide wb;
        wa = a;
        wb = b;
        return (wa * wb) >>> FRAC_BITS;
    endfunction

    function automatic t_word clamp_word(input t_wide v);
        t_wide hi_lim;
        t_wide lo_lim;
        hi_lim = WORD_MAX;
        lo_lim = WORD_MIN;
        if (v > hi_lim) begin
            return WORD_MAX;
        end else if (v < lo_lim) begin
            return WORD_MIN;
        end
        return t_word'(v[WORD_WIDTH-1:0]);
    endfunction

    task automatic load_identity();
        for (int k = 0; k < MAT_ENTRIES; k++) begin
            mat_model[k] = '0;
        end
        mat_model[0] = WORD_ONE;
        mat_model[3] = WORD_ONE;
    endtask

    task automatic apply_cmd(input logic [OP_WIDTH-1:0] op, input logic [1:0] row,
                             input logic [1:0] col, input t_word a, input t_word b);
        t_word  m0;
        t_word  m1;
        t_point p;
        case (op)
            OP_IDENTITY: load_identity();
            OP_SET: begin
                if (row < MAT_ROWS && col < MAT_COLS) begin
                    mat_model[row * MAT_COLS + col] = a;
                end
            end
            OP_TRANSLATE: begin
                mat_model[4] = clamp_word(t_wide'(mat_model[4]) + t_wide'(a));
                mat_model[5] = clamp_word(t_wide'(mat_model[5]) + t_wide'(b));
            end
            OP_SCALE: begin
                for (int r = 0; r < MAT_ROWS; r++) begin
                    mat_model[2*r]   = clamp_word(qmul(mat_model[2*r], a));
                    mat_model[2*r+1] = clamp_word(qmul(mat_model[2*r+1], b));
                end
            end
            OP_ROTATE: begin
                for (int r = 0; r < MAT_ROWS; r++) begin
                    m0 = mat_model[2*r];
                    m1 = mat_model[2*r+1];
                    mat_model[2*r]   = clamp_word(qmul(m0, a) - qmul(m1, b));
                    mat_model[2*r+1] = clamp_word(qmul(m0, b) + qmul(m1, a));
                end
            end
            OP_POINT: begin
                p.x = clamp_word(qmul(a, mat_model[0]) + qmul(b, mat_model[2])
                                 + t_wide'(mat_model[4]));
                p.y = clamp_word(qmul(a, mat_model[1]) + qmul(b, mat_model[3])
                                 + t_wide'(mat_model[5]));
                pending_points.push_back(p);
            end
            default: ;
        endcase
    endtask

    // ---------------- driving ----------------

    // entered just after a falling edge, returns just after one
    task automatic send_cmd(input logic [OP_WIDTH-1:0] op, input logic [1:0] row,
                            input logic [1:0] col, input t_word a, input t_word b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, b, a, col, row};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_cmd(op, row, col, a, b);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ---------------- checking ----------------

    task automatic flag_mismatch(input string what, input t_word got, input t_word want);
        error_count++;
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                flag_mismatch("word with none pending", t_word'(m_axis_tdata[31:0]), '0);
            end else begin
                want = pending_points.pop_front();
                if (t_word'(m_axis_tdata[31:0]) !== want.x) begin
                    flag_mismatch("x_out", t_word'(m_axis_tdata[31:0]), want.x);
                end
                if (t_word'(m_axis_tdata[63:32]) !== want.y) begin
                    flag_mismatch("y_out", t_word'(m_axis_tdata[63:32]), want.y);
                end
            end
        end
    end

    // no handshake on either side for too long means the block hung
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // ---------------- stimulus ----------------

    function automatic t_word pick_arg();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45) begin
            // within +/-8.0
            return t_word'($urandom_range(32'h0010_0000)) - t_word'(32'h0008_0000);
        end else if (sel < 75) begin
            return t_word'($urandom);
        end
        case ($urandom_range(5))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return WORD_ONE;
            4: return -WORD_ONE;
            default: return -1;
        endcase
    endfunction

    task automatic test_identity_points();
        send_cmd(OP_POINT, 2'd0, 2'd0, WORD_MAX, WORD_MIN);
        send_cmd(OP_POINT, 2'd3, 2'd3, '0, '0);
        send_cmd(OP_POINT, 2'd1, 2'd2, -1, 1);
    endtask

    task automatic test_set_entry();
        send_cmd(OP_SET, 2'd0, 2'd0, 32'sh0002_0000, '0);
        send_cmd(OP_SET, 2'd1, 2'd1, -32'sh0001_8000, '0);
        send_cmd(OP_SET, 2'd2, 2'd0, WORD_MAX, '0);
        send_cmd(OP_SET, 2'd2, 2'd1, WORD_MIN, '0);
        // out of range row / col: ignored
        send_cmd(OP_SET, 2'd3, 2'd0, 32'sh5, '0);
        send_cmd(OP_SET, 2'd0, 2'd2, 32'sh5, '0);
        send_cmd(OP_SET, 2'd3, 2'd3, 32'sh5, '0);
        send_cmd(OP_POINT, 2'd0, 2'd0, WORD_ONE, WORD_ONE);
    endtask

    task automatic test_translate_saturation();
        // m20 at max, m21 at min: both pin
        send_cmd(OP_TRANSLATE, 2'd0, 2'd0, WORD_ONE, -WORD_ONE);
        send_cmd(OP_POINT, 2'd0, 2'd0, WORD_MAX, WORD_MIN);
        // identity must clear both offsets, m21 included
        send_cmd(OP_IDENTITY, 2'd3, 2'd3, WORD_MAX, WORD_MAX);
        send_cmd(OP_POINT, 2'd0, 2'd0, 32'sh1, 32'sh1);
    endtask

    task automatic test_scale_rotate();
        send_cmd(OP_SCALE, 2'd0, 2'd0, WORD_MAX, WORD_MIN);
        send_cmd(OP_POINT, 2'd0, 2'd0, WORD_ONE, -1);
        send_cmd(OP_IDENTITY, 2'd0, 2'd0, '0, '0);
        // quarter turn: cos 0, sin 1.0
        send_cmd(OP_ROTATE, 2'd0, 2'd0, '0, WORD_ONE);
        send_cmd(OP_POINT, 2'd0, 2'd0, WORD_ONE, -32'sh3);
    endtask

    task automatic test_spare_ops();
        send_cmd(OP_SPARE_6, 2'd0, 2'd0, WORD_MIN, WORD_MAX);
        send_cmd(OP_SPARE_7, 2'd1, 2'd1, WORD_MAX, WORD_MIN);
        send_cmd(OP_POINT, 2'd0, 2'd0, 32'sh0001_2345, -32'sh0003_4567);
    endtask

    task automatic random_command();
        int unsigned            sel;
        real                    theta;
        logic [OP_WIDTH-1:0]    op;
        logic [1:0]             row;
        logic [1:0]             col;
        t_word                  a;
        t_word                  b;
        sel = $urandom_range(99);
        row = 2'($urandom_range(2));
        col = 2'($urandom_range(1));
        a   = pick_arg();
        b   = pick_arg();
        if (sel < 40) begin
            op = OP_POINT;
        end else if (sel < 55) begin
            op = OP_SET;
            if ($urandom_range(99) < 15) begin
                row = 2'($urandom);
                col = 2'($urandom);
            end
        end else if (sel < 65) begin
            op = OP_TRANSLATE;
        end else if (sel < 75) begin
            op = OP_SCALE;
            if ($urandom_range(1)) begin
                // between -2.0 and 2.0 keeps the matrix usable
                a = t_word'($urandom_range(32'h0004_0000)) - t_word'(32'h0002_0000);
                b = t_word'($urandom_range(32'h0004_0000)) - t_word'(32'h0002_0000);
            end
        end else if (sel < 85) begin
            op = OP_ROTATE;
            if ($urandom_range(3) != 0) begin
                theta = $urandom_range(62831) / 10000.0;
                a = t_word'($rtoi($cos(theta) * 65536.0));
                b = t_word'($rtoi($sin(theta) * 65536.0));
            end
        end else if (sel < 92) begin
            op = OP_IDENTITY;
        end else begin
            op  = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
            row = 2'($urandom);
            col = 2'($urandom);
        end
        send_cmd(op, row, col, a, b);
    endtask

    task automatic test_random_mix(input int items, input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (items) random_command();
    endtask

    initial begin
        load_identity();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_identity_points();
        test_set_entry();
        test_translate_saturation();
        test_scale_rotate();
        test_spare_ops();

        test_random_mix(ITEMS_PER_MODE, 0, 0);
        test_random_mix(ITEMS_PER_MODE, 69, 0);
        test_random_mix(ITEMS_PER_MODE, 0, 69);
        test_random_mix(ITEMS_PER_MODE, 33, 33);

        s_axis_tvalid      <= 1'b0;
        receiver_stall_pct = 0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_points.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/aff_pkg.sv
rtl/aff_mul_array.sv
rtl/aff_exec.sv
rtl/affine_transform_2d_unit.sv
dv/affine_transform_2d_unit_tb.sv
